[rtl/core/sfi_pkg.sv]
// Shared types, character codes and keyword helpers for the script form indexer.
// No dependencies; compiled first.
package sfi_pkg;

  // Parameter defaults
  localparam int NAME_MAX_DEF    = 127;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int DEPTH_BITS_DEF  = 16;

  // Configuration port
  localparam int          CFG_AW           = 3;
  localparam logic [0:0]  REG_NEWLINE_MODE = 1'b0;

  // Characters of interest
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Form type codes, and the "no keyword" code
  localparam logic [1:0] FT_CARD     = 2'd0;
  localparam logic [1:0] FT_HEADER   = 2'd1;
  localparam logic [1:0] FT_MACRODEF = 2'd2;
  localparam logic [1:0] KW_NONE     = 2'd3;

  // Record kinds
  localparam logic REC_FORM   = 1'b0;
  localparam logic REC_STATUS = 1'b1;

  // Keyword text, left justified, one byte per position
  localparam logic [63:0] KW_CARD_TXT     = {"card", 32'h0};
  localparam logic [63:0] KW_HEADER_TXT   = {"header", 16'h0};
  localparam logic [63:0] KW_MACRODEF_TXT = "macrodef";

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_SEEK  = 5'b00001,
    PH_TYPE  = 5'b00010,
    PH_NAME  = 5'b00100,
    PH_CLOSE = 5'b01000,
    PH_NEST  = 5'b10000
  } phase_t;

  // One result item
  typedef struct packed {
    logic        record_kind;
    logic [1:0]  form_type;
    logic [31:0] start_offset;
    logic [31:0] end_offset;
    logic [31:0] name_offset;
    logic [6:0]  name_length;
    logic        parse_ok;
    logic [31:0] error_line;
    logic        last_result;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) ? (c + 8'd32) : c;
  endfunction

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    case (k)
      FT_CARD:     return 4'd4;
      FT_HEADER:   return 4'd6;
      FT_MACRODEF: return 4'd8;
      default:     return 4'd0;
    endcase
  endfunction

  // Keyword byte at a position below its length
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] pos);
    logic [63:0] txt;
    case (k)
      FT_CARD:     txt = KW_CARD_TXT;
      FT_HEADER:   txt = KW_HEADER_TXT;
      FT_MACRODEF: txt = KW_MACRODEF_TXT;
      default:     txt = '0;
    endcase
    return txt[{~pos[2:0], 3'b000} +: 8];
  endfunction

  // Advance the candidate mask by one byte; position saturates at 15
  function automatic logic [6:0] kw_feed(input logic [2:0] mask, input logic [3:0] pos,
                                         input logic [7:0] c);
    logic [2:0] m;
    logic [7:0] lc;
    logic [1:0] kk;
    m  = mask;
    lc = to_lower(c);
    for (int k = 0; k < 3; k++) begin
      kk = 2'(k);
      if (m[k] && !(pos < kw_len(kk) && lc == kw_char(kk, pos))) begin
        m[k] = 1'b0;
      end
    end
    return {m, (pos != 4'd15) ? pos + 4'd1 : pos};
  endfunction

  // First keyword still matching with its full length seen
  function automatic logic [1:0] kw_result(input logic [2:0] mask, input logic [3:0] pos);
    logic [1:0] r;
    r = KW_NONE;
    for (int k = 2; k >= 0; k--) begin
      if (mask[k] && pos == kw_len(2'(k))) begin
        r = 2'(k);
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/sfi_in_if.sv]
// Input channel of the script form indexer: one script byte per request.
// Depends on sfi_pkg (none of its items at present beyond the import style).
interface sfi_in_if;
  import sfi_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] script_byte;
  logic       is_last;

  modport source (output valid, output script_byte, output is_last, input ready);
  modport sink   (input valid, input script_byte, input is_last, output ready);
endinterface

[rtl/core/sfi_out_if.sv]
// Result channel of the script form indexer: form records and status records.
// Depends on sfi_pkg for the field layout.
interface sfi_out_if;
  import sfi_pkg::*;

  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [1:0]  form_type;
  logic [31:0] start_offset;
  logic [31:0] end_offset;
  logic [31:0] name_offset;
  logic [6:0]  name_length;
  logic        parse_ok;
  logic [31:0] error_line;
  logic        last_result;

  modport source (output valid, output record_kind, output form_type, output start_offset,
                  output end_offset, output name_offset, output name_length,
                  output parse_ok, output error_line, output last_result, input ready);
  modport sink   (input valid, input record_kind, input form_type, input start_offset,
                  input end_offset, input name_offset, input name_length,
                  input parse_ok, input error_line, input last_result, output ready);
endinterface

[rtl/core/script_form_indexer.sv]
// Script form indexer top level: byte scanner, parse state and result queue.
// Depends on sfi_pkg, sfi_in_if and sfi_out_if.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in_ch   | in        | valid/ready        | script_byte, is_last
//   out_ch  | out       | valid/ready        | form or status record fields
//   APB     | in        | psel/penable/pwrite| newline_mode at address 0
//
// One byte per cycle while in_ch.ready is high: the whole byte update runs
// combinationally from the parse registers to the parse registers and the result queue.
// A byte yields zero, one or two results; results wait in a 4-entry queue,
// and in_ch.ready stays high while the queue has room for two.
// Results are registered in the queue before they reach out_ch.
// Synchronous active-low reset returns the parser to seeking a form and
// empties the queue; a stalled out_ch stops input once fewer than two
// queue entries are free.
module script_form_indexer #(
  parameter int NAME_MAX    = sfi_pkg::NAME_MAX_DEF,
  parameter int OFFSET_BITS = sfi_pkg::OFFSET_BITS_DEF,
  parameter int DEPTH_BITS  = sfi_pkg::DEPTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  sfi_in_if.sink                      in_ch,
  sfi_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfi_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import sfi_pkg::*;

  localparam int NLEN_W   = $clog2(NAME_MAX + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // State touched by one parsing pass
  typedef struct packed {
    phase_t                  phase;
    logic                    tok;
    logic [2:0]              kw_mask;
    logic [3:0]              kw_pos;
    logic [DEPTH_BITS-1:0]   depth;
    logic [OFFSET_BITS-1:0]  start;
    logic [1:0]              stype;
    logic [OFFSET_BITS-1:0]  name_off;
    logic [NLEN_W-1:0]       nlen;
    logic                    err;
    logic                    emit;
    logic                    again;
  } pass_t;

  // Parse registers
  phase_t                 phase_r, phase_nxt;
  logic                   comment_r, comment_nxt;
  logic                   esc_r, esc_nxt;
  logic                   tok_r, tok_nxt;
  logic [2:0]             kw_mask_r, kw_mask_nxt;
  logic [3:0]             kw_pos_r, kw_pos_nxt;
  logic [DEPTH_BITS-1:0]  depth_r, depth_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [31:0]            line_r, line_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [1:0]             stype_r, stype_nxt;
  logic [OFFSET_BITS-1:0] noff_r, noff_nxt;
  logic [NLEN_W-1:0]      nlen_r, nlen_nxt;
  logic                   err_r, err_nxt;
  logic                   nl_mode_r;

  // Result queue
  result_t                queue_r [OQ_DEPTH];
  logic [OQ_AW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [OQ_CW-1:0]       count_r;

  logic                   in_fire, out_fire, cfg_wr;
  logic                   form_emit, stat_emit;
  result_t                form_rec, stat_rec, push_a, push_b;
  logic [1:0]             n_push;

  function automatic logic [31:0] off32(input logic [OFFSET_BITS-1:0] x);
    logic [OFFSET_BITS+31:0] w;
    w = {32'd0, x};
    return w[31:0];
  endfunction

  function automatic logic [6:0] len7(input logic [NLEN_W-1:0] x);
    logic [NLEN_W+6:0] w;
    w = {7'd0, x};
    return w[6:0];
  endfunction

  // One pass of the phase machine over the current byte
  function automatic pass_t do_pass(input pass_t s, input logic [7:0] c, input logic esc,
                                    input logic vis, input logic paren,
                                    input logic [OFFSET_BITS-1:0] off);
    pass_t      r;
    logic [1:0] kwr;
    r       = s;
    r.again = 1'b0;
    kwr     = kw_result(s.kw_mask, s.kw_pos);
    case (s.phase)
      PH_SEEK: begin
        if (vis) begin
          if (c == CH_LPAREN && !esc) begin
            r.start = off;
            r.phase = PH_TYPE;
            r.tok   = 1'b0;
          end else begin
            r.err = 1'b1;
          end
        end
      end
      PH_TYPE, PH_NAME, PH_NEST: begin
        if (!s.tok) begin
          // waiting for a token to start
          if (vis) begin
            if (paren) begin
              if (s.phase == PH_NEST) begin
                r.phase = PH_CLOSE;
                r.again = 1'b1;
              end else begin
                r.err = 1'b1;
              end
            end else begin
              r.tok = 1'b1;
              if (s.phase == PH_NAME) begin
                r.name_off = off;
                r.nlen     = NLEN_W'(1);
              end else begin
                {r.kw_mask, r.kw_pos} = kw_feed(3'b111, 4'd0, c);
              end
            end
          end
        end else if (!is_space(c) && !(c == CH_HASH && !esc) && !paren) begin
          // token continues
          if (s.phase == PH_NAME) begin
            if (s.nlen >= NLEN_W'(NAME_MAX)) begin
              r.err = 1'b1;
            end else begin
              r.nlen = s.nlen + NLEN_W'(1);
            end
          end else begin
            {r.kw_mask, r.kw_pos} = kw_feed(s.kw_mask, s.kw_pos, c);
          end
        end else begin
          // token ends; a paren is handled again by the next phase
          r.tok = 1'b0;
          if (s.phase == PH_TYPE) begin
            if (kwr == KW_NONE) begin
              r.err = 1'b1;
            end else begin
              r.stype = kwr;
              r.phase = PH_NAME;
              r.again = paren;
            end
          end else if (s.phase == PH_NAME) begin
            r.phase = PH_CLOSE;
            r.again = paren;
          end else begin
            if (kwr != KW_NONE) begin
              r.err = 1'b1;
            end else begin
              r.phase = PH_CLOSE;
              r.again = paren;
            end
          end
        end
      end
      default: begin
        // body: balance parens
        if (vis && !esc) begin
          if (c == CH_LPAREN) begin
            if (s.depth == '1) begin
              r.err = 1'b1;
            end else begin
              r.depth = s.depth + DEPTH_BITS'(1);
              r.phase = PH_NEST;
              r.tok   = 1'b0;
            end
          end else if (c == CH_RPAREN) begin
            if (s.depth == '0) begin
              r.emit  = 1'b1;
              r.phase = PH_SEEK;
            end else begin
              r.depth = s.depth - DEPTH_BITS'(1);
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // Byte update
  always_comb begin
    logic [7:0] c;
    logic       esc, vis, paren, is_nl, err_end;
    pass_t      ps;
    c       = in_ch.script_byte;
    esc     = esc_r;
    vis     = 1'b0;
    paren   = 1'b0;
    is_nl   = 1'b0;
    err_end = 1'b0;

    phase_nxt   = phase_r;
    comment_nxt = comment_r;
    esc_nxt     = esc_r;
    tok_nxt     = tok_r;
    kw_mask_nxt = kw_mask_r;
    kw_pos_nxt  = kw_pos_r;
    depth_nxt   = depth_r;
    off_nxt     = off_r;
    line_nxt    = line_r;
    start_nxt   = start_r;
    stype_nxt   = stype_r;
    noff_nxt    = noff_r;
    nlen_nxt    = nlen_r;
    err_nxt     = err_r;
    form_emit   = 1'b0;

    ps       = '0;
    ps.phase = phase_r;

    if (!err_r) begin
      // comment, escape and line tracking
      esc_nxt = 1'b0;
      is_nl   = (c == CH_LF) || (nl_mode_r && c == CH_CR);
      if (is_nl) begin
        comment_nxt = 1'b0;
        if (line_r != '1) begin
          line_nxt = line_r + 32'd1;
        end
      end else if (c == CH_HASH && !esc) begin
        comment_nxt = 1'b1;
      end else if (c == CH_BSLASH && !esc) begin
        esc_nxt = 1'b1;
      end
      vis   = !is_space(c) && !comment_nxt;
      paren = !esc && (c == CH_LPAREN || c == CH_RPAREN);

      // phase machine, re-run when a paren is handed on
      ps.tok      = tok_r;
      ps.kw_mask  = kw_mask_r;
      ps.kw_pos   = kw_pos_r;
      ps.depth    = depth_r;
      ps.start    = start_r;
      ps.stype    = stype_r;
      ps.name_off = noff_r;
      ps.nlen     = nlen_r;
      ps.again    = 1'b1;
      for (int p = 0; p < 3; p++) begin
        if (ps.again && !ps.err) begin
          ps = do_pass(ps, c, esc, vis, paren, off_r);
        end
      end
      phase_nxt   = ps.phase;
      tok_nxt     = ps.tok;
      kw_mask_nxt = ps.kw_mask;
      kw_pos_nxt  = ps.kw_pos;
      depth_nxt   = ps.depth;
      start_nxt   = ps.start;
      stype_nxt   = ps.stype;
      noff_nxt    = ps.name_off;
      nlen_nxt    = ps.nlen;
      err_nxt     = ps.err;
      form_emit   = ps.emit;
      off_nxt     = off_r + OFFSET_BITS'(1);
    end

    stat_emit = in_ch.is_last;
    err_end   = err_nxt || (phase_nxt != PH_SEEK);

    form_rec              = '0;
    form_rec.record_kind  = REC_FORM;
    form_rec.form_type    = stype_nxt;
    form_rec.start_offset = off32(start_nxt);
    form_rec.end_offset   = off32(off_r);
    form_rec.name_offset  = off32(noff_nxt);
    form_rec.name_length  = len7(nlen_nxt);
    form_rec.last_result  = !stat_emit;

    stat_rec             = '0;
    stat_rec.record_kind = REC_STATUS;
    stat_rec.parse_ok    = !err_end;
    stat_rec.error_line  = line_nxt;
    stat_rec.last_result = 1'b1;

    // end of file: back to reset values
    if (stat_emit) begin
      phase_nxt   = PH_SEEK;
      comment_nxt = 1'b0;
      esc_nxt     = 1'b0;
      tok_nxt     = 1'b0;
      kw_mask_nxt = '0;
      kw_pos_nxt  = '0;
      depth_nxt   = '0;
      off_nxt     = '0;
      line_nxt    = 32'd1;
      start_nxt   = '0;
      stype_nxt   = '0;
      noff_nxt    = '0;
      nlen_nxt    = '0;
      err_nxt     = 1'b0;
    end

    push_a = form_emit ? form_rec : stat_rec;
    push_b = stat_rec;
    n_push = in_fire ? ({1'b0, form_emit} + {1'b0, stat_emit}) : 2'd0;
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SEEK;
      comment_r <= 1'b0;
      esc_r     <= 1'b0;
      tok_r     <= 1'b0;
      kw_mask_r <= '0;
      kw_pos_r  <= '0;
      depth_r   <= '0;
      off_r     <= '0;
      line_r    <= 32'd1;
      start_r   <= '0;
      stype_r   <= '0;
      noff_r    <= '0;
      nlen_r    <= '0;
      err_r     <= 1'b0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      comment_r <= comment_nxt;
      esc_r     <= esc_nxt;
      tok_r     <= tok_nxt;
      kw_mask_r <= kw_mask_nxt;
      kw_pos_r  <= kw_pos_nxt;
      depth_r   <= depth_nxt;
      off_r     <= off_nxt;
      line_r    <= line_nxt;
      start_r   <= start_nxt;
      stype_r   <= stype_nxt;
      noff_r    <= noff_nxt;
      nlen_r    <= nlen_nxt;
      err_r     <= err_nxt;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nl_mode_r <= 1'b0;
    end else if (cfg_wr && paddr[CFG_AW-1:2] == REG_NEWLINE_MODE) begin
      nl_mode_r <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[CFG_AW-1:2] == REG_NEWLINE_MODE) ? {31'd0, nl_mode_r} : 32'd0;

  // Result queue storage
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue_r[wr_ptr_r] <= push_a;
    end
    if (n_push == 2'd2) begin
      queue_r[wr_ptr_r + OQ_AW'(1)] <= push_b;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OQ_AW'(n_push);
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + OQ_AW'(1);
      end
      count_r <= count_r + OQ_CW'(n_push) - OQ_CW'(out_fire);
    end
  end

  assign in_ch.ready         = (count_r <= OQ_CW'(OQ_DEPTH - 2));
  assign out_ch.valid        = (count_r != '0);
  assign out_ch.record_kind  = queue_r[rd_ptr_r].record_kind;
  assign out_ch.form_type    = queue_r[rd_ptr_r].form_type;
  assign out_ch.start_offset = queue_r[rd_ptr_r].start_offset;
  assign out_ch.end_offset   = queue_r[rd_ptr_r].end_offset;
  assign out_ch.name_offset  = queue_r[rd_ptr_r].name_offset;
  assign out_ch.name_length  = queue_r[rd_ptr_r].name_length;
  assign out_ch.parse_ok     = queue_r[rd_ptr_r].parse_ok;
  assign out_ch.error_line   = queue_r[rd_ptr_r].error_line;
  assign out_ch.last_result  = queue_r[rd_ptr_r].last_result;

endmodule

[tb/script_form_indexer_test.sv]
// Self-checking testbench for the script form indexer: random script files plus directed cases,
// checked against a cycle-free predictor of the form and status records.
// Depends on sfi_pkg, sfi_in_if, sfi_out_if and script_form_indexer.
module script_form_indexer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sfi_pkg::*;

  localparam int          PERIOD         = 10;
  localparam int          CYCLE_LIMIT    = 1_000_000;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          PRESSURE_PHASE = 3;
  localparam int          NAME_LIMIT     = NAME_MAX_DEF;
  localparam int unsigned DEPTH_LIMIT    = (1 << DEPTH_BITS_DEF) - 1;
  localparam logic [CFG_AW-1:0] NL_MODE_ADDR = CFG_AW'(4 * REG_NEWLINE_MODE);
  localparam logic [7:0]  CH_SPACE       = 8'h20;
  localparam logic [7:0]  CH_TAB         = 8'h09;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } script_item_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata, prdata;
  logic              pready;

  sfi_in_if  in_bus ();
  sfi_out_if out_bus ();

  script_form_indexer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Stimulus and bookkeeping
  script_item_t script_stream[$];
  logic [7:0]   file_bytes[$];
  result_t      expected_records[$];
  int           queued_total   = 0;
  int           accepted_total = 0;
  int           form_records   = 0;
  int           status_records = 0;
  int           mismatches     = 0;
  int           cycles         = 0;
  int           send_idle_pct  = 0;
  int           recv_idle_pct  = 0;
  int           test_phase     = 0;
  int           hold_left      = 0;
  logic         hold_done      = 1'b0;
  logic         in_taken       = 1'b0;

  // Scanner state mirrored by the predictor
  logic        nl_mode;
  phase_t      scan_phase;
  logic        in_cmt, esc_pend, tok_on, err;
  logic [63:0] tok_text;
  logic [3:0]  tok_len;
  int unsigned depth;
  logic [31:0] offset, line_no, form_start, name_off;
  logic [1:0]  form_kind;
  int          name_len;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [7:0] lower_ch(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  function automatic void clear_scan();
    scan_phase = PH_SEEK;
    in_cmt     = 1'b0;
    esc_pend   = 1'b0;
    tok_on     = 1'b0;
    tok_text   = '0;
    tok_len    = '0;
    depth      = 0;
    offset     = '0;
    line_no    = 32'd1;
    form_start = '0;
    form_kind  = FT_CARD;
    name_off   = '0;
    name_len   = 0;
    err        = 1'b0;
  endfunction

  // Keep the last eight lowered token bytes; the length saturates at 15
  function automatic void take_kw_char(input logic [7:0] c);
    tok_text = {tok_text[55:0], lower_ch(c)};
    if (tok_len != 4'd15) tok_len++;
  endfunction

  function automatic logic [1:0] token_keyword();
    if (tok_len == 4'd4 && tok_text[31:0] == "card") return FT_CARD;
    if (tok_len == 4'd6 && tok_text[47:0] == "header") return FT_HEADER;
    if (tok_len == 4'd8 && tok_text == "macrodef") return FT_MACRODEF;
    return KW_NONE;
  endfunction

  // Predict the records caused by one accepted byte
  function automatic void index_byte(input logic [7:0] c, input logic last);
    logic    escaped, real_b, paren, again;
    int      pass, n;
    result_t recs[2];
    n = 0;
    if (!err) begin
      escaped  = esc_pend;
      esc_pend = 1'b0;
      if (c == CH_LF || (nl_mode && c == CH_CR)) begin
        in_cmt = 1'b0;
        if (line_no != '1) line_no++;
      end else if (c == CH_HASH && !escaped) begin
        in_cmt = 1'b1;
      end else if (c == CH_BSLASH && !escaped) begin
        esc_pend = 1'b1;
      end
      real_b = !is_blank(c) && !in_cmt;
      paren  = !escaped && (c == CH_LPAREN || c == CH_RPAREN);
      again  = 1'b1;
      // a paren that ends a token is handled again by the next phase
      for (pass = 0; pass < 3 && again && !err; pass++) begin
        again = 1'b0;
        case (scan_phase)
          PH_SEEK: begin
            if (real_b) begin
              if (c == CH_LPAREN && !escaped) begin
                form_start = offset;
                scan_phase = PH_TYPE;
                tok_on     = 1'b0;
              end else begin
                err = 1'b1;
              end
            end
          end
          PH_TYPE, PH_NAME, PH_NEST: begin
            if (!tok_on) begin
              if (real_b && paren) begin
                if (scan_phase == PH_NEST) begin
                  scan_phase = PH_CLOSE;
                  again      = 1'b1;
                end else begin
                  err = 1'b1;
                end
              end else if (real_b) begin
                tok_on = 1'b1;
                if (scan_phase == PH_NAME) begin
                  name_off = offset;
                  name_len = 1;
                end else begin
                  tok_text = '0;
                  tok_len  = '0;
                  take_kw_char(c);
                end
              end
            end else if (!is_blank(c) && !(c == CH_HASH && !escaped) && !paren) begin
              if (scan_phase != PH_NAME) begin
                take_kw_char(c);
              end else if (name_len >= NAME_LIMIT) begin
                err = 1'b1;
              end else begin
                name_len++;
              end
            end else begin
              tok_on = 1'b0;
              if (scan_phase == PH_TYPE) begin
                if (token_keyword() == KW_NONE) begin
                  err = 1'b1;
                end else begin
                  form_kind  = token_keyword();
                  scan_phase = PH_NAME;
                  again      = paren;
                end
              end else if (scan_phase == PH_NAME || token_keyword() == KW_NONE) begin
                scan_phase = PH_CLOSE;
                again      = paren;
              end else begin
                err = 1'b1;
              end
            end
          end
          default: begin
            if (real_b && !escaped && c == CH_LPAREN) begin
              if (depth >= DEPTH_LIMIT) begin
                err = 1'b1;
              end else begin
                depth++;
                scan_phase = PH_NEST;
                tok_on     = 1'b0;
              end
            end else if (real_b && !escaped && c == CH_RPAREN) begin
              if (depth == 0) begin
                recs[n]              = '0;
                recs[n].record_kind  = REC_FORM;
                recs[n].form_type    = form_kind;
                recs[n].start_offset = form_start;
                recs[n].end_offset   = offset;
                recs[n].name_offset  = name_off;
                recs[n].name_length  = name_len[6:0];
                n++;
                scan_phase = PH_SEEK;
              end else begin
                depth--;
              end
            end
          end
        endcase
      end
      offset++;
    end
    // end of file: status record, then back to the initial state
    if (last) begin
      if (!err && scan_phase != PH_SEEK) err = 1'b1;
      recs[n]             = '0;
      recs[n].record_kind = REC_STATUS;
      recs[n].parse_ok    = !err;
      recs[n].error_line  = line_no;
      n++;
      clear_scan();
    end
    if (n > 0) recs[n - 1].last_result = 1'b1;
    for (int i = 0; i < n; i++) expected_records.push_back(recs[i]);
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Byte sender: holds each request until it is taken
  always @(negedge clk) begin : send_bytes
    script_item_t it;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (script_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = script_stream.pop_front();
        in_bus.valid       <= 1'b1;
        in_bus.script_byte <= it.data;
        in_bus.is_last     <= it.last;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Record receiver, with one long hold-off in the pressure phase
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else if (test_phase == PRESSURE_PHASE && !hold_done) begin
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on accepted bytes, check accepted records
  always @(posedge clk) begin : watch_channels
    result_t got, want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_bus.valid && in_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        index_byte(in_bus.script_byte, in_bus.is_last);
        accepted_total++;
      end
      if (out_bus.valid && out_bus.ready) begin
        got.record_kind  = out_bus.record_kind;
        got.form_type    = out_bus.form_type;
        got.start_offset = out_bus.start_offset;
        got.end_offset   = out_bus.end_offset;
        got.name_offset  = out_bus.name_offset;
        got.name_length  = out_bus.name_length;
        got.parse_ok     = out_bus.parse_ok;
        got.error_line   = out_bus.error_line;
        got.last_result  = out_bus.last_result;
        if (got.record_kind === REC_STATUS) status_records++;
        else form_records++;
        if (expected_records.size() == 0) begin
          $display("%0t: unexpected record, expected none, actual 0x%0h", $time, got);
          mismatches++;
        end else begin
          want = expected_records.pop_front();
          check_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
          check_field("form_type", 32'(want.form_type), 32'(got.form_type));
          check_field("start_offset", want.start_offset, got.start_offset);
          check_field("end_offset", want.end_offset, got.end_offset);
          check_field("name_offset", want.name_offset, got.name_offset);
          check_field("name_length", 32'(want.name_length), 32'(got.name_length));
          check_field("parse_ok", 32'(want.parse_ok), 32'(got.parse_ok));
          check_field("error_line", want.error_line, got.error_line);
          check_field("last_result", 32'(want.last_result), 32'(got.last_result));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d records still due, %0d of %0d bytes taken", $time,
               expected_records.size(), accepted_total, queued_total);
      $display("FAILURE");
      $finish;
    end
  end

  // Script builders: bytes collect in file_bytes, flush_file marks the last one
  task automatic flush_file();
    script_item_t it;
    foreach (file_bytes[i]) begin
      it.data = file_bytes[i];
      it.last = (i == file_bytes.size() - 1);
      script_stream.push_back(it);
    end
    queued_total += file_bytes.size();
    file_bytes.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endtask

  task automatic script_file(input string s);
    add_text(s);
    flush_file();
  endtask

  // Whitespace and comments between tokens
  task automatic add_gap();
    int pieces, r, n;
    pieces = $urandom_range(1, 2);
    repeat (pieces) begin
      r = $urandom_range(9);
      if (r < 5) begin
        file_bytes.push_back(CH_SPACE);
      end else if (r == 5) begin
        file_bytes.push_back(CH_TAB);
      end else if (r == 6) begin
        file_bytes.push_back(CH_LF);
      end else if (r == 7) begin
        file_bytes.push_back(CH_CR);
      end else begin
        file_bytes.push_back(CH_HASH);
        n = $urandom_range(6);
        repeat (n) file_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
        file_bytes.push_back((nl_mode && $urandom_range(1)) ? CH_CR : CH_LF);
      end
    end
  endtask

  task automatic add_word(input int n);
    string pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-.:*!?";
    string esc_pool = "()#\\ q";
    int i;
    i = 0;
    while (i < n) begin
      if (i < n - 1 && $urandom_range(11) == 0) begin
        file_bytes.push_back(CH_BSLASH);
        file_bytes.push_back(esc_pool[$urandom_range(esc_pool.len() - 1)]);
        i += 2;
      end else begin
        file_bytes.push_back(pool[$urandom_range(pool.len() - 1)]);
        i++;
      end
    end
  endtask

  task automatic add_keyword();
    string kw;
    logic [7:0] ch;
    case ($urandom_range(2))
      0:       kw = "card";
      1:       kw = "header";
      default: kw = "macrodef";
    endcase
    for (int i = 0; i < kw.len(); i++) begin
      ch = kw[i];
      if ($urandom_range(3) == 0) ch = ch - 8'h20;
      file_bytes.push_back(ch);
    end
  endtask

  // Nested group inside a form body
  task automatic add_group(input int lvl);
    int items;
    file_bytes.push_back(CH_LPAREN);
    if ($urandom_range(1)) add_gap();
    add_word($urandom_range(1, 6));
    items = $urandom_range(2);
    repeat (items) begin
      if (lvl < 3 && $urandom_range(2) == 0) begin
        if ($urandom_range(1)) add_gap();
        add_group(lvl + 1);
      end else begin
        add_gap();
        add_word($urandom_range(1, 6));
      end
    end
    if ($urandom_range(1)) add_gap();
    file_bytes.push_back(CH_RPAREN);
  endtask

  task automatic add_form();
    int items;
    file_bytes.push_back(CH_LPAREN);
    if ($urandom_range(2) == 0) add_gap();
    add_keyword();
    add_gap();
    add_word(($urandom_range(19) == 0) ? $urandom_range(100, 127) : $urandom_range(1, 10));
    items = $urandom_range(3);
    repeat (items) begin
      case ($urandom_range(3))
        0: begin
          if ($urandom_range(1)) add_gap();
          add_group(1);
        end
        1: begin
          add_gap();
          add_text("\\)");
        end
        default: begin
          add_gap();
          add_word($urandom_range(1, 8));
        end
      endcase
    end
    if ($urandom_range(1)) add_gap();
    file_bytes.push_back(CH_RPAREN);
  endtask

  task automatic add_file();
    int forms;
    if ($urandom_range(2) == 0) add_gap();
    forms = $urandom_range(1, 3);
    for (int i = 0; i < forms; i++) begin
      if (i != 0 && $urandom_range(3) != 0) add_gap();
      add_form();
    end
    if ($urandom_range(1)) add_gap();
  endtask

  // Broken files: one byte replaced, one inserted, or the file cut short
  task automatic corrupt_file();
    int pos;
    pos = $urandom_range(file_bytes.size() - 1);
    case ($urandom_range(2))
      0:       file_bytes[pos] = 8'($urandom_range(255));
      1:       file_bytes.insert(pos, 8'($urandom_range(255)));
      default: while (file_bytes.size() > pos + 1) void'(file_bytes.pop_back());
    endcase
  endtask

  task automatic random_scripts(input int budget);
    int first, r, n;
    first = queued_total;
    while (queued_total - first < budget) begin
      r = $urandom_range(99);
      if (r < 15) begin
        n = $urandom_range(1, 10);
        repeat (n) file_bytes.push_back(8'($urandom_range(255)));
      end else begin
        add_file();
        if (r < 30) corrupt_file();
      end
      flush_file();
    end
  endtask

  task automatic directed_scripts();
    script_file("(card a)");
    script_file("(HEADER hdr (x y) \\) z)\n");
    script_file(" \t(MacroDef m#note\n  body (p (q)) )\n");
    script_file("(card#c\n n)");
    script_file("(card\\ n)");              // escaped space ends a bad type token
    script_file("x");                       // stray byte at top level
    script_file("(cards n)");               // not a keyword
    script_file("((card n))");              // paren where the type belongs
    script_file("(card )");                 // missing name
    script_file("(card(n))");
    script_file("(card n (header q))");     // keyword in a nested group
    script_file("(card n (x y");            // file ends inside a form
    script_file("\\(card n)");              // escaped paren is stray
    script_file("# (card a\n(card n)\015\n");
    script_file("x\n\n(card n)\n");         // error stays, line count frozen
    script_file(" ");
    script_file("\n");
    script_file("(card n)x");
    // extreme byte values inside a name
    add_text("(card ");
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h80);
    script_file(")");
    // longest legal name, then one byte over
    add_text("(header ");
    repeat (NAME_LIMIT) file_bytes.push_back("n");
    script_file(")");
    add_text("(header ");
    repeat (NAME_LIMIT + 1) file_bytes.push_back("n");
    script_file(")");
  endtask

  // CR ends a comment only in the CR-or-LF newline mode
  task automatic newline_cases();
    script_file("(card n #c\015)\015");
    script_file("\015\015\n");
  endtask

  task automatic write_newline_mode(input logic v);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= NL_MODE_ADDR;
    pwdata  <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    nl_mode = v;
    @(posedge clk);
  endtask

  // Wait until every queued byte is taken and every record has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_total != queued_total || expected_records.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    in_bus.valid       = 1'b0;
    in_bus.script_byte = '0;
    in_bus.is_last     = 1'b0;
    out_bus.ready      = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    nl_mode            = 1'b0;
    clear_scan();
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // LF only; slow sender, slower receiver
    write_newline_mode(1'b0);
    send_idle_pct = 36;
    recv_idle_pct = 75;
    test_phase    = 1;
    directed_scripts();
    newline_cases();
    random_scripts(270);
    wait_drained();

    // CR or LF; roles swapped
    write_newline_mode(1'b1);
    send_idle_pct = 75;
    recv_idle_pct = 36;
    test_phase    = 2;
    newline_cases();
    random_scripts(270);
    wait_drained();

    // full rate, with one long receiver hold-off
    write_newline_mode(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_phase    = PRESSURE_PHASE;
    random_scripts(270);
    wait_drained();

    $display("Scanned %0d script bytes under both newline modes and stall patterns;",
             accepted_total);
    $display("checked %0d form records and %0d status records, %0d mismatches.",
             form_records, status_records, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/sfi_pkg.sv
rtl/core/sfi_in_if.sv
rtl/core/sfi_out_if.sv
rtl/core/script_form_indexer.sv
tb/script_form_indexer_test.sv
